@@ hdl/tld_pkg.sv @@
`default_nettype none
package tld_pkg;

	localparam int ECHO_DEPTH = 1024;
	localparam int LINE_DEPTH = 4096;
	localparam int ECHO_AW = $clog2(ECHO_DEPTH);
	localparam int ECHO_FW = $clog2(ECHO_DEPTH + 1);
	localparam int LINE_AW = $clog2(LINE_DEPTH);
	localparam int LINE_FW = $clog2(LINE_DEPTH + 1);
	localparam int COL_W = 16;

	typedef logic [7:0] char_t;

	localparam logic [1:0] REQ_RX     = 2'd0;
	localparam logic [1:0] REQ_TXDONE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam char_t CH_BS    = 8'h08;
	localparam char_t CH_DEL   = 8'h7F;
	localparam char_t CH_BELL  = 8'h07;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_LF    = 8'h0A;
	localparam char_t CH_SPACE = 8'h20;

endpackage
`default_nettype wire

@@ hdl/terminal_line_discipline_unit.sv @@
`default_nettype none
// Canonical line discipline of one terminal with echo. Each accepted input word first reads
// the echo ring and the line ring (both synchronous memories); the stage then updates them and
// loads the result register once the output register is free or being taken. A received
// character that queues two echo bytes at once holds off the next input word for the second
// echo ring write. Exactly one result word is produced per input word, and the output
// register lets the next input word be taken while a result still waits.
module terminal_line_discipline_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // rx_char
	input  wire logic [1:0]  s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // tx_char, read_char
	output logic [1:0]       m_tuser,  // tx_valid, read_valid
	output logic             m_tlast   // read_line_end
);

	localparam int EAW = tld_pkg::ECHO_AW;
	localparam int EFW = tld_pkg::ECHO_FW;
	localparam int LAW = tld_pkg::LINE_AW;
	localparam int LFW = tld_pkg::LINE_FW;
	localparam int CW  = tld_pkg::COL_W;
	localparam logic [EAW-1:0] E_LAST = EAW'(tld_pkg::ECHO_DEPTH - 1);
	localparam logic [LAW-1:0] L_LAST = LAW'(tld_pkg::LINE_DEPTH - 1);
	localparam logic [EFW-1:0] E_FULL = EFW'(tld_pkg::ECHO_DEPTH);
	localparam logic [LFW-1:0] L_FULL = LFW'(tld_pkg::LINE_DEPTH);
	localparam logic [CW-1:0]  COL_MAX = {CW{1'b1}};

	tld_pkg::char_t echo_mem [tld_pkg::ECHO_DEPTH];
	tld_pkg::char_t line_mem [tld_pkg::LINE_DEPTH];

	logic [EAW-1:0] ewp_q, erp_q;
	logic [EFW-1:0] efill_q;
	logic           wrapped_q;
	logic [CW-1:0]  col_q;
	logic [LAW-1:0] lwp_q, lrp_q;
	logic [LFW-1:0] lfill_q, clines_q;
	logic           idle_q, esn_q;

	logic           s1_valid_q;
	logic [1:0]     req_s1;
	tld_pkg::char_t ch_s1, erd0_s1, erd1_s1, lrd_s1;
	logic           v1_s1;

	logic           pend_q;
	logic [EAW-1:0] pend_a_q;

	logic           out_valid_q;
	logic           tx_v_q, rv_q, re_q;
	tld_pkg::char_t tx_c_q, rc_q;

	logic           acc, s1_fire;
	logic [EAW-1:0] ewp_inc, ewp_inc2, erp_inc, erp_dec;
	logic [LAW-1:0] lwp_inc, lwp_dec, lrp_inc, lrd_a;
	logic [EFW-1:0] efree;

	logic           e_we, pend_set;
	logic [EAW-1:0] e_wa;
	tld_pkg::char_t e_wd, d1, c2, last;
	logic           l_we, p1, p2, erase;
	logic [EFW-1:0] fill1, fill2;

	logic [EAW-1:0] ewp_d, erp_d;
	logic [EFW-1:0] efill_d;
	logic [CW-1:0]  col_d;
	logic [LAW-1:0] lwp_d, lrp_d;
	logic [LFW-1:0] lfill_d, clines_d;
	logic           idle_d, esn_d;
	logic           tx_v, rv, re;
	tld_pkg::char_t tx_c, rc;

	assign s_tready = !s1_valid_q && !pend_q;
	assign acc      = s_tvalid && s_tready;
	assign s1_fire  = s1_valid_q && (!out_valid_q || m_tready);

	assign ewp_inc  = (ewp_q == E_LAST) ? '0 : ewp_q + 1'b1;
	assign ewp_inc2 = (ewp_inc == E_LAST) ? '0 : ewp_inc + 1'b1;
	assign erp_inc  = (erp_q == E_LAST) ? '0 : erp_q + 1'b1;
	assign erp_dec  = (erp_q == '0) ? E_LAST : erp_q - 1'b1;
	assign lwp_inc  = (lwp_q == L_LAST) ? '0 : lwp_q + 1'b1;
	assign lwp_dec  = (lwp_q == '0) ? L_LAST : lwp_q - 1'b1;
	assign lrp_inc  = (lrp_q == L_LAST) ? '0 : lrp_q + 1'b1;
	assign lrd_a    = (s_tuser == tld_pkg::REQ_READ) ? lrp_q : lwp_dec;
	assign efree    = E_FULL - efill_q;

	always_ff @(posedge clk) begin
		if (e_we)
			echo_mem[e_wa] <= e_wd;
		else if (pend_q)
			echo_mem[pend_a_q] <= tld_pkg::CH_BELL;
		if (acc) begin
			erd0_s1 <= echo_mem[erp_q];
			erd1_s1 <= echo_mem[erp_dec];
		end
	end

	always_ff @(posedge clk) begin
		if (l_we)
			line_mem[lwp_q] <= c2;
		if (acc)
			lrd_s1 <= line_mem[lrd_a];
	end

	always_comb begin
		ewp_d = ewp_q; erp_d = erp_q; efill_d = efill_q; col_d = col_q;
		lwp_d = lwp_q; lrp_d = lrp_q; lfill_d = lfill_q; clines_d = clines_q;
		idle_d = idle_q; esn_d = esn_q;
		e_we = 1'b0; e_wa = ewp_q; e_wd = tld_pkg::CH_BELL; pend_set = 1'b0;
		l_we = 1'b0; p1 = 1'b0; p2 = 1'b0; d1 = tld_pkg::CH_BELL;
		fill1 = efill_q; fill2 = efill_q;
		tx_v = 1'b0; tx_c = '0; rv = 1'b0; rc = '0; re = 1'b0;
		erase = (ch_s1 == tld_pkg::CH_BS) || (ch_s1 == tld_pkg::CH_DEL);
		c2 = (ch_s1 == tld_pkg::CH_CR) ? tld_pkg::CH_LF : ch_s1;
		last = v1_s1 ? erd1_s1 : '0;
		if (s1_fire) begin
			case (req_s1)
				tld_pkg::REQ_RX: begin
					if (erase) begin
						if (col_q != '0 && efill_q < E_FULL) begin
							p1 = 1'b1; d1 = tld_pkg::CH_BS; col_d = col_q - 1'b1;
						end
					end else if (efree > EFW'(1)) begin
						p1 = 1'b1; d1 = ch_s1;
						if (col_q != COL_MAX)
							col_d = col_q + 1'b1;
					end else if (efree == EFW'(1)) begin
						p1 = 1'b1;
					end
					fill1 = efill_q + EFW'(p1);
					if (erase) begin
						if (lfill_q != '0 && lrd_s1 != tld_pkg::CH_LF) begin
							lwp_d = lwp_dec; lfill_d = lfill_q - 1'b1;
						end
					end else if (lfill_q < L_FULL) begin
						l_we = 1'b1; lwp_d = lwp_inc; lfill_d = lfill_q + 1'b1;
						if (c2 == tld_pkg::CH_LF)
							clines_d = clines_q + 1'b1;
					end else if (fill1 < E_FULL) begin
						p2 = 1'b1;
					end
					fill2 = fill1 + EFW'(p2);
					if (p1 || p2) begin
						e_we = 1'b1; e_wd = p1 ? d1 : tld_pkg::CH_BELL;
						ewp_d = ewp_inc;
					end
					if (p1 && p2) begin
						pend_set = 1'b1; ewp_d = ewp_inc2;
					end
					efill_d = fill2;
					if (idle_q && fill2 != '0) begin
						tx_v = 1'b1;
						tx_c = (efill_q == '0) ? e_wd : erd0_s1;
						erp_d = erp_inc; efill_d = fill2 - 1'b1; idle_d = 1'b0;
					end
				end
				tld_pkg::REQ_TXDONE: begin
					if (last == tld_pkg::CH_CR) begin
						tx_v = 1'b1; tx_c = tld_pkg::CH_LF;
						e_we = 1'b1; e_wa = erp_dec; e_wd = tld_pkg::CH_LF;
						idle_d = 1'b0; col_d = '0;
					end else if (last == tld_pkg::CH_BS) begin
						tx_v = 1'b1; idle_d = 1'b0;
						if (esn_q) begin
							tx_c = tld_pkg::CH_SPACE; esn_d = 1'b0;
						end else begin
							tx_c = tld_pkg::CH_BS; esn_d = 1'b1;
							e_we = 1'b1; e_wa = erp_dec; e_wd = tld_pkg::CH_LF;
						end
					end else if (efill_q != '0) begin
						tx_v = 1'b1; tx_c = erd0_s1;
						erp_d = erp_inc; efill_d = efill_q - 1'b1; idle_d = 1'b0;
					end else begin
						idle_d = 1'b1;
					end
				end
				tld_pkg::REQ_READ: begin
					if (clines_q != '0 && lfill_q != '0) begin
						rv = 1'b1; rc = lrd_s1;
						lrp_d = lrp_inc; lfill_d = lfill_q - 1'b1;
						if (lrd_s1 == tld_pkg::CH_LF) begin
							re = 1'b1; clines_d = clines_q - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ewp_q <= '0; erp_q <= '0; efill_q <= '0; wrapped_q <= 1'b0; col_q <= '0;
			lwp_q <= '0; lrp_q <= '0; lfill_q <= '0; clines_q <= '0;
			idle_q <= 1'b1; esn_q <= 1'b1;
			s1_valid_q <= 1'b0; pend_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			ewp_q <= ewp_d; erp_q <= erp_d; efill_q <= efill_d; col_q <= col_d;
			wrapped_q <= wrapped_q || (ewp_d < ewp_q);
			lwp_q <= lwp_d; lrp_q <= lrp_d; lfill_q <= lfill_d; clines_q <= clines_d;
			idle_q <= idle_d; esn_q <= esn_d;
			pend_q <= pend_set;
			if (acc)
				s1_valid_q <= 1'b1;
			else if (s1_fire)
				s1_valid_q <= 1'b0;
			if (s1_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1 <= s_tuser;
			ch_s1  <= s_tdata;
			v1_s1  <= wrapped_q || (erp_dec < ewp_q);
		end
		if (pend_set)
			pend_a_q <= ewp_inc;
		if (s1_fire) begin
			tx_v_q <= tx_v; tx_c_q <= tx_c; rv_q <= rv; rc_q <= rc; re_q <= re;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {rc_q, tx_c_q};
	assign m_tuser  = {rv_q, tx_v_q};
	assign m_tlast  = re_q;

	a_efill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		efill_q <= E_FULL) else $error("echo fill beyond depth");
	a_lines_bound: assert property (@(posedge clk) disable iff (!arst_n)
		clines_q <= lfill_q) else $error("more committed lines than characters");
	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(s1_fire) && !s1_valid_q) else $error("stray second echo write");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid_q && !pend_q) else $error("word accepted over busy stage");

endmodule
`default_nettype wire
